// ===== rtl/core/qrmm_pkg.sv =====
`default_nettype none
package qrmm_pkg;
   localparam int VAL_W = 31;
   localparam int COORD_W = 9;
   localparam int CSR_W = 9;
   localparam int CSR_IDX_W = 1;
   localparam logic [VAL_W-1:0] EMPTY_MIN = 31'd2147483644;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 1'b1;

   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/qrmm_if.sv =====
`default_nettype none
interface qrmm_req_if;
   import qrmm_pkg::*;
   logic valid;
   logic ready;
   logic kind;
   logic [COORD_W-1:0] row_lo;
   logic [COORD_W-1:0] col_lo;
   logic [COORD_W-1:0] row_hi;
   logic [COORD_W-1:0] col_hi;
   logic [VAL_W-1:0] new_value;
   modport source (output valid, kind, row_lo, col_lo, row_hi, col_hi, new_value,
                   input ready);
   modport sink (input valid, kind, row_lo, col_lo, row_hi, col_hi, new_value,
                 output ready);
endinterface

interface qrmm_rsp_if;
   import qrmm_pkg::*;
   logic valid;
   logic ready;
   logic [VAL_W-1:0] max_value;
   logic [VAL_W-1:0] min_value;
   modport source (output valid, max_value, min_value, input ready);
   modport sink (input valid, max_value, min_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/quadtree_range_min_max.sv =====
// Range max/min over a GRID_SIDE x GRID_SIDE grid kept as a complete quadtree in
// one synchronous node memory holding {max, min} per node. After reset a clearing
// pass writes every node, one per cycle; requests are held off until it finishes,
// configuration writes are taken at any time. An update writes its leaf, then
// re-folds each ancestor with four child reads and one write through the memory's
// read and write ports. A query walks the tree with an on-chip stack, one node
// per cycle; the count of nodes visited depends on the rectangle. One request is
// in work at a time; a finished result sits in an output register so the next
// request can be taken while it waits.
`default_nettype none
module quadtree_range_min_max #(
   parameter int GRID_SIDE = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   qrmm_req_if.sink                               req_bus,
   qrmm_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_wr_en,
   input  wire logic [qrmm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [qrmm_pkg::CSR_W-1:0]        csr_wdata
);
   import qrmm_pkg::*;

   localparam int L = $clog2(GRID_SIDE);
   localparam int NODES = (4 * GRID_SIDE * GRID_SIDE - 1) / 3;
   localparam int LEAF_OFF = (GRID_SIDE * GRID_SIDE - 1) / 3;
   localparam int AW = $clog2(NODES);
   localparam int LW = $clog2(L + 1);
   localparam int CW = ((L + 1 > COORD_W) ? L + 1 : COORD_W) + 1;
   localparam int STK = 3 * L + 1;
   localparam int PW = $clog2(STK + 1);
   localparam int IW = $clog2(STK);

   typedef struct packed {
      logic [AW-1:0] idx;
      logic [LW-1:0] lvl;
      logic [L-1:0]  xb;
      logic [L-1:0]  yb;
      logic [CW-1:0] qa;
      logic [CW-1:0] qb;
      logic [CW-1:0] qc;
      logic [CW-1:0] qd;
   } ent_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LEAF, ST_UREAD, ST_UWAIT, ST_WALK, ST_DONE
   } state_type;

   function automatic ent_type mk_child(ent_type p, logic [1:0] k, logic [CW-1:0] half,
                                        logic [CW-1:0] a, logic [CW-1:0] b,
                                        logic [CW-1:0] c, logic [CW-1:0] d);
      ent_type e;
      e.idx = AW'({p.idx, 2'b00}) + AW'(k) + AW'(1);
      e.lvl = p.lvl + LW'(1);
      e.xb = L'(CW'(p.xb) + (k[1] ? half : CW'(0)));
      e.yb = L'(CW'(p.yb) + (k[0] ? half : CW'(0)));
      e.qa = a;
      e.qb = b;
      e.qc = c;
      e.qd = d;
      return e;
   endfunction

   // node memory, {max, min}
   logic [2*VAL_W-1:0] mem [NODES];
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [2*VAL_W-1:0] mem_wdata;
   logic [AW-1:0]      mem_raddr;
   logic [2*VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   state_type state_ff, state_in;
   logic [CSR_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [AW-1:0] nidx_ff, nidx_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [1:0] k_ff, k_in;
   logic rd_vld_ff, rd_vld_in, rd_use_ff, rd_use_in;
   logic [VAL_W-1:0] acc_max_ff, acc_max_in, acc_min_ff, acc_min_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] out_max_ff, out_max_in, out_min_ff, out_min_in;
   ent_type st_ff [STK];
   ent_type st_in [STK];
   logic [PW-1:0] sp_ff, sp_in;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.max_value = out_max_ff;
   assign rsp_bus.min_value = out_min_ff;

   logic [CW-1:0] rows_x, cols_x;
   logic [L-1:0] px, py;
   logic in_grid;
   logic [2*L-1:0] mort;
   logic [AW-1:0] leaf_idx;
   logic [VAL_W-1:0] f_max, f_min;
   logic [CW-1:0] u_size, u_half, u_xb, u_yb, u_cx2, u_cy2;
   ent_type top;
   logic [CW-1:0] w_size, w_half, x1, x2, y1, y2, mx, my;
   logic w_skip, w_match, w_leaf;
   ent_type ch [4];
   logic [2:0] n_ch;

   always_comb begin
      rows_x = CW'(rows_ff);
      cols_x = CW'(cols_ff);
      px = L'(row_ff - COORD_W'(1));
      py = L'(col_ff - COORD_W'(1));
      in_grid = (row_ff != '0) && (col_ff != '0) &&
                (CW'(row_ff) <= CW'(GRID_SIDE)) && (CW'(col_ff) <= CW'(GRID_SIDE));
      // leaves follow all inner nodes, in row/column bit-interleaved order
      mort = '0;
      for (int i = 0; i < L; i++) begin
         mort[2*i+1] = px[i];
         mort[2*i]   = py[i];
      end
      leaf_idx = AW'(LEAF_OFF) + AW'(mort);

      // fold the child read issued last cycle
      f_max = acc_max_ff;
      f_min = acc_min_ff;
      if (rd_vld_ff && rd_use_ff) begin
         if (rd_data_ff[2*VAL_W-1:VAL_W] > f_max) f_max = rd_data_ff[2*VAL_W-1:VAL_W];
         if (rd_data_ff[VAL_W-1:0] < f_min) f_min = rd_data_ff[VAL_W-1:0];
      end

      // update: child k of the node on the path at level lvl
      u_size = CW'(GRID_SIDE) >> lvl_ff;
      u_half = u_size >> 1;
      u_xb = CW'(px) & ~(u_size - CW'(1));
      u_yb = CW'(py) & ~(u_size - CW'(1));
      u_cx2 = u_xb + u_half + (k_ff[1] ? u_half : CW'(0));
      u_cy2 = u_yb + u_half + (k_ff[0] ? u_half : CW'(0));

      // query walk on the top of the stack
      top = st_ff[IW'(sp_ff - PW'(1))];
      w_size = CW'(GRID_SIDE) >> top.lvl;
      w_half = w_size >> 1;
      x1 = CW'(top.xb) + CW'(1);
      x2 = CW'(top.xb) + w_size;
      y1 = CW'(top.yb) + CW'(1);
      y2 = CW'(top.yb) + w_size;
      mx = CW'(top.xb) + w_half;
      my = CW'(top.yb) + w_half;
      w_skip = (x1 > rows_x) || (y1 > cols_x);
      w_match = (x1 == top.qa) && (x2 == top.qc) && (y1 == top.qb) && (y2 == top.qd);
      w_leaf = (top.lvl == LW'(L));
      for (int j = 0; j < 4; j++) ch[j] = top;
      n_ch = 3'd0;
      priority if (x1 <= top.qa && y1 <= top.qb && mx >= top.qc && my >= top.qd) begin
         ch[0] = mk_child(top, 2'd0, w_half, top.qa, top.qb, top.qc, top.qd);
         n_ch = 3'd1;
      end else if (my < top.qb && y2 >= top.qd && mx >= top.qc && x1 <= top.qa) begin
         ch[0] = mk_child(top, 2'd1, w_half, top.qa, top.qb, top.qc, top.qd);
         n_ch = 3'd1;
      end else if (my >= top.qd && top.qb >= y1 && top.qc <= x2 && mx < top.qa) begin
         ch[0] = mk_child(top, 2'd2, w_half, top.qa, top.qb, top.qc, top.qd);
         n_ch = 3'd1;
      end else if (mx < top.qa && my < top.qb && x2 >= top.qc && y2 >= top.qd) begin
         ch[0] = mk_child(top, 2'd3, w_half, top.qa, top.qb, top.qc, top.qd);
         n_ch = 3'd1;
      end else if (mx < top.qc && top.qa <= mx && my >= top.qd && y1 <= top.qb) begin
         ch[0] = mk_child(top, 2'd0, w_half, top.qa, top.qb, mx, top.qd);
         ch[1] = mk_child(top, 2'd2, w_half, mx + CW'(1), top.qb, top.qc, top.qd);
         n_ch = 3'd2;
      end else if (mx < top.qc && top.qa <= mx && my < top.qb && y2 >= top.qd) begin
         ch[0] = mk_child(top, 2'd1, w_half, top.qa, top.qb, mx, top.qd);
         ch[1] = mk_child(top, 2'd3, w_half, mx + CW'(1), top.qb, top.qc, top.qd);
         n_ch = 3'd2;
      end else if (top.qa >= x1 && top.qc <= mx && top.qb <= my && top.qd > my) begin
         ch[0] = mk_child(top, 2'd0, w_half, top.qa, top.qb, top.qc, my);
         ch[1] = mk_child(top, 2'd1, w_half, top.qa, my + CW'(1), top.qc, top.qd);
         n_ch = 3'd2;
      end else if (mx < top.qa && x2 >= top.qc && top.qb <= my && top.qd > my) begin
         ch[0] = mk_child(top, 2'd2, w_half, top.qa, top.qb, top.qc, my);
         ch[1] = mk_child(top, 2'd3, w_half, top.qa, my + CW'(1), top.qc, top.qd);
         n_ch = 3'd2;
      end else begin
         ch[0] = mk_child(top, 2'd0, w_half, top.qa, top.qb, mx, my);
         ch[1] = mk_child(top, 2'd1, w_half, top.qa, my + CW'(1), mx, top.qd);
         ch[2] = mk_child(top, 2'd2, w_half, mx + CW'(1), top.qb, top.qc, my);
         ch[3] = mk_child(top, 2'd3, w_half, mx + CW'(1), my + CW'(1), top.qc, top.qd);
         n_ch = 3'd4;
      end
   end

   always_comb begin
      state_in = state_ff;
      rows_in = rows_ff;
      cols_in = cols_ff;
      clr_in = clr_ff;
      row_in = row_ff;
      col_in = col_ff;
      val_in = val_ff;
      nidx_in = nidx_ff;
      lvl_in = lvl_ff;
      k_in = k_ff;
      rd_vld_in = 1'b0;
      rd_use_in = 1'b0;
      acc_max_in = f_max;
      acc_min_in = f_min;
      out_max_in = out_max_ff;
      out_min_in = out_min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      st_in = st_ff;
      sp_in = sp_ff;
      mem_we = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = {{VAL_W{1'b0}}, EMPTY_MIN};
      mem_raddr = top.idx;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRID_ROWS: rows_in = csr_wdata;
            REG_GRID_COLS: cols_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(NODES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               row_in = req_bus.row_lo;
               col_in = req_bus.col_lo;
               val_in = req_bus.new_value;
               if (req_bus.kind == KIND_UPDATE) begin
                  state_in = ST_LEAF;
               end else if (rows_ff == '0 || cols_ff == '0) begin
                  acc_max_in = '0;
                  acc_min_in = '0;
                  state_in = ST_DONE;
               end else begin
                  st_in[0].idx = '0;
                  st_in[0].lvl = '0;
                  st_in[0].xb = '0;
                  st_in[0].yb = '0;
                  st_in[0].qa = CW'(req_bus.row_lo);
                  st_in[0].qb = CW'(req_bus.col_lo);
                  st_in[0].qc = CW'(req_bus.row_hi);
                  st_in[0].qd = CW'(req_bus.col_hi);
                  sp_in = PW'(1);
                  acc_max_in = '0;
                  acc_min_in = EMPTY_MIN;
                  state_in = ST_WALK;
               end
            end
         end
         ST_LEAF: begin
            // a point off the grid touches no leaf, only the root is refolded
            if (in_grid) begin
               mem_we = 1'b1;
               mem_waddr = leaf_idx;
               mem_wdata = {val_ff, val_ff};
               nidx_in = AW'((leaf_idx - AW'(1)) >> 2);
               lvl_in = LW'(L - 1);
            end else begin
               nidx_in = '0;
               lvl_in = '0;
            end
            k_in = 2'd0;
            acc_max_in = '0;
            acc_min_in = EMPTY_MIN;
            state_in = ST_UREAD;
         end
         ST_UREAD: begin
            mem_raddr = AW'({nidx_ff, 2'b00}) + AW'(k_ff) + AW'(1);
            rd_vld_in = 1'b1;
            rd_use_in = (u_cx2 <= rows_x) && (u_cy2 <= cols_x);
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) state_in = ST_UWAIT;
         end
         ST_UWAIT: begin
            mem_we = 1'b1;
            mem_waddr = nidx_ff;
            mem_wdata = {f_max, f_min};
            acc_max_in = '0;
            acc_min_in = EMPTY_MIN;
            k_in = 2'd0;
            if (lvl_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               lvl_in = lvl_ff - LW'(1);
               nidx_in = AW'((nidx_ff - AW'(1)) >> 2);
               state_in = ST_UREAD;
            end
         end
         ST_WALK: begin
            if (sp_ff == '0) begin
               state_in = ST_DONE;
            end else if (w_skip || (w_leaf && !w_match)) begin
               sp_in = sp_ff - PW'(1);
            end else if (w_match) begin
               rd_vld_in = 1'b1;
               rd_use_in = 1'b1;
               sp_in = sp_ff - PW'(1);
            end else begin
               // pop the node, push its pieces in its slot and above
               for (int i = 0; i < STK; i++) begin
                  for (int j = 0; j < 4; j++) begin
                     if (j < int'(n_ch) && i == int'(sp_ff) - 1 + j) st_in[i] = ch[j];
                  end
               end
               sp_in = PW'(sp_ff - PW'(1) + PW'(n_ch));
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_max_in = acc_max_ff;
               out_min_in = acc_min_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rows_ff <= '0;
         cols_ff <= '0;
         clr_ff <= '0;
         rd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sp_ff <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         clr_ff <= clr_in;
         rd_vld_ff <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff <= sp_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      val_ff <= val_in;
      nidx_ff <= nidx_in;
      lvl_ff <= lvl_in;
      k_ff <= k_in;
      rd_use_ff <= rd_use_in;
      acc_max_ff <= acc_max_in;
      acc_min_ff <= acc_min_in;
      out_max_ff <= out_max_in;
      out_min_ff <= out_min_in;
      st_ff <= st_in;
   end
endmodule
`default_nettype wire
